@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by edit_distance_similarity.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked on the rising clock edge and
// held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/eds_pkg.sv @@
// ----------------------------------------------------------------------------
// eds_pkg
// Command codes and widths for the edit distance similarity block.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam logic [1:0] CMD_REF    = 2'd0;
  localparam logic [1:0] CMD_CAND   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Longest string held; the result field widths are sized for it.
  localparam int MaxLen = 64;

  localparam int unsigned PctW     = 14;
  localparam int unsigned PctScale = 100;

endpackage

@@ rtl/eds_div.sv @@
// ----------------------------------------------------------------------------
// eds_div
// Restoring divider, one quotient bit per cycle, for the percentage.
// ----------------------------------------------------------------------------
module eds_div #(
  parameter int unsigned NumW = 18,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/edit_distance_similarity.sv @@
// ----------------------------------------------------------------------------
// edit_distance_similarity
// Levenshtein distance and similarity percentage of two loaded byte strings.
// ----------------------------------------------------------------------------
// Channel | Direction | Fields (low bit up)
// s_axis  | in        | tuser: cmd[1:0]; tdata: ch[7:0]
// m_axis  | out       | tdata: distance[6:0], similarity_percent[20:7],
//         |           |        reference_empty[21], truncated[22]
//
// Byte loads can be taken back to back. A finish first seeds the cost row,
// then updates it once per reference byte, one cell at a time through the
// one read and one write port of the cost row memory, then divides. An
// empty string skips the cell updates, and an empty reference skips the
// division.
// Reset clears the state, lengths and the overflow flag; memories need no clearing.
// The input stalls from a finish until its result is taken.
// ----------------------------------------------------------------------------
module edit_distance_similarity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance[6:0], similarity_percent[20:7], reference_empty[21], truncated[22]
  output logic [23:0] m_axis_tdata
);
  import eds_pkg::*;

  localparam int unsigned AW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned LW   = $clog2(MaxLen + 1);
  localparam int unsigned RW   = $clog2(MaxLen + 2);
  localparam int unsigned NumW = LW + 8;
  localparam int unsigned DenW = LW;
  localparam logic [LW-1:0] LenMax = LW'(MaxLen);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_ROW  = 3'd2;
  localparam logic [2:0] ST_CELL = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam logic [2:0] ST_DIVW = 3'd7;

  logic [7:0]    ref_mem  [MaxLen];
  logic [7:0]    cand_mem [MaxLen];
  logic [LW-1:0] row_mem  [MaxLen+1];

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] rlen_q, rlen_d, clen_q, clen_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] i_q, i_d, j_q, j_d;
  logic [LW-1:0] diag_q, diag_d, left_q, left_d;
  logic [7:0]    rch_q;
  logic [7:0]    cch_q;
  logic [LW-1:0] up_q;
  logic [LW-1:0] dist_q, dist_d;
  logic          empty_q, empty_d, trunc_q, trunc_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic          neg_q, neg_d;

  logic [1:0]    cmd;
  logic [7:0]    ch;
  logic          in_fire;
  logic          out_fire;

  logic          row_we;
  logic [RW-1:0] row_wa, row_ra;
  logic [LW-1:0] row_wd;
  logic [LW:0]   cell_a, cell_b, cell_c, cell_m;

  logic          div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [LW:0]   diff;
  logic [LW:0]   diff_abs;

  assign cmd     = s_axis_tuser;
  assign ch      = s_axis_tdata;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Byte stores
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd == CMD_REF && rlen_q < LenMax) begin
      ref_mem[rlen_q[AW-1:0]] <= ch;
    end
    if (in_fire && cmd == CMD_CAND && clen_q < LenMax) begin
      cand_mem[clen_q[AW-1:0]] <= ch;
    end
    rch_q <= ref_mem[i_d[AW-1:0] - AW'(1)];
    cch_q <= cand_mem[j_d[AW-1:0] - AW'(1)];
  end

  // Cost row memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    up_q <= row_mem[row_ra];
  end

  assign cell_a = {1'b0, up_q} + 1'b1;
  assign cell_b = {1'b0, left_q} + 1'b1;
  assign cell_c = {1'b0, diag_q} + ((rch_q == cch_q) ? 1'b0 : 1'b1);
  always_comb begin
    cell_m = (cell_a < cell_b) ? cell_a : cell_b;
    if (cell_c < cell_m) begin
      cell_m = cell_c;
    end
  end

  assign diff     = {1'b0, rlen_q} - {1'b0, dist_q};
  assign diff_abs = diff[LW] ? (~diff + 1'b1) : diff;
  assign div_num  = NumW'(diff_abs[LW-1:0]) * NumW'(PctScale);

  always_comb begin
    state_d = state_q;
    rlen_d = rlen_q; clen_d = clen_q; ovf_d = ovf_q;
    i_d = i_q; j_d = j_q; diag_d = diag_q; left_d = left_q;
    dist_d = dist_q; empty_d = empty_q; trunc_d = trunc_q;
    pct_d = pct_q; neg_d = neg_q;
    row_we = 1'b0; row_wa = '0; row_wd = '0; row_ra = '0;
    div_start = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          case (cmd)
            CMD_REF: begin
              if (rlen_q < LenMax) rlen_d = rlen_q + 1'b1;
              else ovf_d = 1'b1;
            end
            CMD_CAND: begin
              if (clen_q < LenMax) clen_d = clen_q + 1'b1;
              else ovf_d = 1'b1;
            end
            CMD_FINISH: begin
              j_d = '0;
              state_d = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        row_we = 1'b1;
        row_wa = RW'(j_q);
        row_wd = j_q;
        j_d = j_q + 1'b1;
        if (j_q == clen_q) begin
          i_d = LW'(1);
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (i_q > rlen_q || clen_q == '0) begin
          row_ra = RW'(clen_q);
          dist_d = (clen_q == '0) ? rlen_q : dist_q;
          state_d = (clen_q == '0) ? ST_DIV : ST_WAIT;
        end else begin
          // Start row i: write entry 0 with i, take i-1 as the old diagonal, read entry 1.
          row_we = 1'b1;
          row_wa = '0;
          row_wd = i_q;
          diag_d = i_q - 1'b1;
          left_d = i_q;
          j_d = LW'(1);
          row_ra = RW'(1);
          state_d = ST_CELL;
        end
      end
      ST_CELL: begin
        // up_q holds row[j]; write new row[j], read row[j+1].
        row_we = 1'b1;
        row_wa = RW'(j_q);
        row_wd = cell_m[LW-1:0];
        diag_d = up_q;
        left_d = cell_m[LW-1:0];
        j_d = j_q + 1'b1;
        row_ra = RW'(j_q + 1'b1);
        if (j_q == clen_q) begin
          if (i_q == rlen_q) dist_d = cell_m[LW-1:0];
          i_d = i_q + 1'b1;
          state_d = (i_q == rlen_q) ? ST_DIV : ST_ROW;
        end
      end
      ST_WAIT: begin
        dist_d = up_q;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        empty_d = (rlen_q == '0);
        trunc_d = ovf_q;
        neg_d = diff[LW];
        if (rlen_q == '0) begin
          pct_d = '0;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          pct_d = neg_q ? PctW'(~div_quot + 1'b1) : PctW'(div_quot);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          rlen_d = '0; clen_d = '0; ovf_d = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  eds_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rlen_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rlen_q  <= '0;
      clen_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rlen_q  <= rlen_d;
      clen_q  <= clen_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; diag_q <= diag_d; left_q <= left_d;
    dist_q <= dist_d; empty_q <= empty_d; trunc_q <= trunc_d;
    pct_q <= pct_d; neg_q <= neg_d;
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {1'b0, trunc_q, empty_q, pct_q, 7'(dist_q)};

`include "assert_macros.svh"

  `ASSERT_CLK(a_len_bound, clk_i, rst_ni, rlen_q <= LenMax && clen_q <= LenMax, "length over limit")
  `ASSERT_CLK(a_no_accept_busy, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready, "input while busy")
  `ASSERT_CLK(a_clear, clk_i, rst_ni, out_fire |=> (rlen_q == '0 && !ovf_q), "not cleared")

endmodule
